[design/sbh_pkg.sv]
// Shared types and constants for the spatial bisection hash block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package sbh_pkg;

  // Coordinate and code geometry
  localparam int COORD_BITS    = 32;
  localparam int MAX_STEPS_DEF = 21;
  localparam int HASH_BITS     = 64;
  localparam int COUNT_BITS    = 4;
  localparam int STEP_BITS     = 5;
  localparam int DIM_BITS      = 2;
  localparam int INDEX_BITS    = 4;
  localparam int BYTE_BITS     = 8;
  localparam int BYTE_SHIFT    = 3;
  localparam int TOTAL_BITS    = 7;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Input word: one point
  typedef struct packed {
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
  } point_t;

  // Output word: one hash result
  typedef struct packed {
    logic [HASH_BITS-1:0]  hash_code;
    logic [COUNT_BITS-1:0] byte_count;
    logic                  range_error;
  } result_t;

  // Configuration register map
  typedef enum logic [INDEX_BITS-1:0] {
    CFG_X_LOW      = 4'd0,
    CFG_X_HIGH     = 4'd1,
    CFG_Y_LOW      = 4'd2,
    CFG_Y_HIGH     = 4'd3,
    CFG_Z_LOW      = 4'd4,
    CFG_Z_HIGH     = 4'd5,
    CFG_DIM_COUNT  = 4'd6,
    CFG_STEP_COUNT = 4'd7
  } cfg_idx_t;

  localparam logic [DIM_BITS-1:0]  DIMS_3D     = 2'd3;
  localparam logic [DIM_BITS-1:0]  DIMS_RESET  = 2'd2;
  localparam logic [STEP_BITS-1:0] STEPS_RESET = 5'd21;

endpackage

[design/spatial_bisection_hash.sv]
// Top level of the spatial bisection hash: configuration registers, three
// axis lanes, merge stage and valid tracking. Depends on sbh_pkg, sbh_lane, sbh_merge.
`timescale 1ns / 1ps

// A new point is taken every clock cycle; busy is high only while rst is held.
// Each point gives exactly one result word, shown for one cycle with done high,
// after it passes the range check and entry register, one pipeline stage per
// bisection step in each axis lane, and the merge register. The receiver cannot
// stall results, and results leave in the order the points came in. Write
// configuration only while no point is in flight.
module spatial_bisection_hash #(
  parameter int MAX_STEPS = sbh_pkg::MAX_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  sbh_pkg::point_t                point,
  output logic                           done,
  output sbh_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sbh_pkg::INDEX_BITS-1:0] cfg_index,
  input  sbh_pkg::coord_t                cfg_data
);
  import sbh_pkg::*;

  localparam int LAT = MAX_STEPS + 2;
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  coord_t x_low, x_high, y_low, y_high, z_low, z_high;
  logic [DIM_BITS-1:0]  dimension_count;
  logic [STEP_BITS-1:0] step_count;
  logic [STEP_BITS-1:0] steps_eff;
  logic                 dims3;
  logic                 accept;
  logic [LAT-1:0]       vld;

  logic [MAX_STEPS-1:0] bits_x, bits_y, bits_z;
  logic                 bad_x, bad_y, bad_z;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low           <= COORD_MIN;
      x_high          <= COORD_MAX;
      y_low           <= COORD_MIN;
      y_high          <= COORD_MAX;
      z_low           <= COORD_MIN;
      z_high          <= COORD_MAX;
      dimension_count <= DIMS_RESET;
      step_count      <= STEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_X_LOW:      x_low           <= cfg_data;
        CFG_X_HIGH:     x_high          <= cfg_data;
        CFG_Y_LOW:      y_low           <= cfg_data;
        CFG_Y_HIGH:     y_high          <= cfg_data;
        CFG_Z_LOW:      z_low           <= cfg_data;
        CFG_Z_HIGH:     z_high          <= cfg_data;
        CFG_DIM_COUNT:  dimension_count <= DIM_BITS'(cfg_data);
        CFG_STEP_COUNT: step_count      <= STEP_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // Clamp step count into 1..MAX_STEPS; anything but three axes is 2D
  assign dims3     = (dimension_count == DIMS_3D);
  assign steps_eff = (step_count == '0) ? STEP_BITS'(1) :
                     (step_count > STEP_BITS'(MAX_STEPS)) ? STEP_BITS'(MAX_STEPS) :
                     step_count;

  // Track words through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld << 1) | LAT'(accept);
    end
  end

  assign done = vld[LAT-1];

  sbh_lane #(.MAX_STEPS(MAX_STEPS)) u_lane_x (
    .clk(clk), .low(x_low), .high(x_high), .coord(point.coord_x),
    .bits(bits_x), .bad(bad_x)
  );

  sbh_lane #(.MAX_STEPS(MAX_STEPS)) u_lane_y (
    .clk(clk), .low(y_low), .high(y_high), .coord(point.coord_y),
    .bits(bits_y), .bad(bad_y)
  );

  sbh_lane #(.MAX_STEPS(MAX_STEPS)) u_lane_z (
    .clk(clk), .low(z_low), .high(z_high), .coord(point.coord_z),
    .bits(bits_z), .bad(bad_z)
  );

  sbh_merge #(.MAX_STEPS(MAX_STEPS)) u_merge (
    .clk(clk),
    .bits_x(bits_x), .bits_y(bits_y), .bits_z(bits_z),
    .bad_x(bad_x), .bad_y(bad_y), .bad_z(bad_z),
    .dims3(dims3), .steps(steps_eff),
    .result(result)
  );

  // Every accepted point comes out after the fixed latency
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted point did not produce a result");

  // No result without a matching accepted point
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without an accepted point");

  // Error results carry an empty code
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    done && result.range_error |-> result.hash_code == '0 && result.byte_count == '0)
    else $error("error result with nonzero code or count");

  // Good results carry one to eight bytes
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done && !result.range_error |->
      result.byte_count != '0 && result.byte_count <= COUNT_BITS'(BYTE_BITS))
    else $error("byte count out of range");

endmodule

[design/sbh_lane.sv]
// One axis lane of the spatial bisection hash: range check, then one
// bisection step per pipeline stage. Depends on sbh_pkg.
`timescale 1ns / 1ps

module sbh_lane #(
  parameter int MAX_STEPS = sbh_pkg::MAX_STEPS_DEF
) (
  input  logic                 clk,
  input  sbh_pkg::coord_t      low,
  input  sbh_pkg::coord_t      high,
  input  sbh_pkg::coord_t      coord,
  output logic [MAX_STEPS-1:0] bits,
  output logic                 bad
);
  import sbh_pkg::*;

  localparam logic [COORD_BITS-1:0] SIGN_BIT = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [COORD_BITS-1:0] b_low;
  logic [COORD_BITS-1:0] b_high;
  logic [COORD_BITS-1:0] b_val;
  logic                  out_of_range;

  logic [COORD_BITS-1:0] resid  [0:MAX_STEPS];
  logic [COORD_BITS-1:0] span   [0:MAX_STEPS];
  logic [MAX_STEPS-1:0]  bitvec [0:MAX_STEPS];
  logic                  err    [0:MAX_STEPS];

  // Offset-binary form so unsigned compares follow signed order
  assign b_low  = COORD_BITS'(low)   ^ SIGN_BIT;
  assign b_high = COORD_BITS'(high)  ^ SIGN_BIT;
  assign b_val  = COORD_BITS'(coord) ^ SIGN_BIT;
  assign out_of_range = (b_low >= b_high) || (b_val < b_low) || (b_val > b_high);

  // Entry stage: span and starting residual
  always_ff @(posedge clk) begin
    err[0]    <= out_of_range;
    bitvec[0] <= '0;
    if (out_of_range) begin
      span[0]  <= COORD_BITS'(1);
      resid[0] <= '0;
    end else begin
      span[0]  <= b_high - b_low;
      resid[0] <= b_val - b_low;
    end
  end

  // Bisection stages: double the residual, take the upper half when it fits
  for (genvar k = 1; k <= MAX_STEPS; k++) begin : g_step
    logic [COORD_BITS:0] twice;
    logic                take;

    assign twice = {resid[k-1], 1'b0};
    assign take  = (twice >= {1'b0, span[k-1]});

    always_ff @(posedge clk) begin
      err[k]    <= err[k-1];
      span[k]   <= span[k-1];
      bitvec[k] <= (bitvec[k-1] << 1) | MAX_STEPS'(take);
      if (take) begin
        resid[k] <= COORD_BITS'(twice - {1'b0, span[k-1]});
      end else begin
        resid[k] <= COORD_BITS'(twice);
      end
    end
  end

  assign bits = bitvec[MAX_STEPS];
  assign bad  = err[MAX_STEPS];

endmodule

[design/sbh_merge.sv]
// Merge stage of the spatial bisection hash: interleaves lane bits,
// masks unused steps, counts bytes and registers the result word. Depends on sbh_pkg.
`timescale 1ns / 1ps

module sbh_merge #(
  parameter int MAX_STEPS = sbh_pkg::MAX_STEPS_DEF
) (
  input  logic                          clk,
  input  logic [MAX_STEPS-1:0]          bits_x,
  input  logic [MAX_STEPS-1:0]          bits_y,
  input  logic [MAX_STEPS-1:0]          bits_z,
  input  logic                          bad_x,
  input  logic                          bad_y,
  input  logic                          bad_z,
  input  logic                          dims3,
  input  logic [sbh_pkg::STEP_BITS-1:0] steps,
  output sbh_pkg::result_t              result
);
  import sbh_pkg::*;

  logic [HASH_BITS-1:0]  code;
  logic [TOTAL_BITS-1:0] total;
  logic [COUNT_BITS-1:0] nbytes;
  logic                  bad;

  // Interleave x, y (and z in 3D mode) per step, first bit at the top
  always_comb begin
    code = '0;
    for (int j = 0; j < MAX_STEPS; j++) begin
      if (STEP_BITS'(j) < steps) begin
        if (dims3) begin
          code[HASH_BITS-1-3*j]   = bits_x[MAX_STEPS-1-j];
          code[HASH_BITS-2-3*j]   = bits_y[MAX_STEPS-1-j];
          code[HASH_BITS-3-3*j]   = bits_z[MAX_STEPS-1-j];
        end else begin
          code[HASH_BITS-1-2*j]   = bits_x[MAX_STEPS-1-j];
          code[HASH_BITS-2-2*j]   = bits_y[MAX_STEPS-1-j];
        end
      end
    end
  end

  // Round bit total up to whole bytes
  assign total  = (TOTAL_BITS'(steps) << 1) + (dims3 ? TOTAL_BITS'(steps) : '0);
  assign nbytes = COUNT_BITS'((total + TOTAL_BITS'(BYTE_BITS - 1)) >> BYTE_SHIFT);
  assign bad    = bad_x || bad_y || (dims3 && bad_z);

  // Register the result word
  always_ff @(posedge clk) begin
    if (bad) begin
      result.hash_code   <= '0;
      result.byte_count  <= '0;
      result.range_error <= 1'b1;
    end else begin
      result.hash_code   <= code;
      result.byte_count  <= nbytes;
      result.range_error <= 1'b0;
    end
  end

endmodule
